### rtl/ioc_pkg.sv
// Shared constants and types for the in-order completion window.
package ioc_pkg;

  // Window of completion marks starting at the head id
  localparam int WINDOW    = 16;
  localparam int IDX_W     = $clog2(WINDOW);
  localparam int RUN_W     = $clog2(WINDOW + 1);

  // Fixed field widths
  localparam int ID_W      = 64;
  localparam int SEED_W    = 64;
  localparam int ACT_W     = 2;
  localparam int CNT_W     = 16;
  localparam int COUNT_W   = 5;
  localparam int START_MAX = 31;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Action codes of an input word
  localparam logic [ACT_W-1:0] ACT_DONE   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CANCEL = 2'd1;
  localparam logic [ACT_W-1:0] ACT_START  = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;  // take the input word this cycle
    logic step;    // retire one more id and slide the window
  } ioc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic retire_hit;  // the word completes the head id
    logic mark0;       // the id now at the head is already done
  } ioc_stat_t;

endpackage

### rtl/ioc_ctrl.sv
// Controller: accepts words and sequences the retire scan over the window.
module ioc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  output logic                done_o,
  input  ioc_pkg::ioc_stat_t  stat_i,
  output ioc_pkg::ioc_cmd_t   cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e state_q;
  logic   done_q;

  assign busy   = (state_q == ST_SCAN);
  assign done_o = done_q;

  // Commands to the datapath
  always_comb begin
    cmd_o        = '0;
    cmd_o.accept = (state_q == ST_IDLE) && start;
    cmd_o.step   = (state_q == ST_SCAN) && stat_i.mark0;
  end

  // State and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            if (stat_i.retire_hit) begin
              state_q <= ST_SCAN;
            end else begin
              done_q <= 1'b1;
            end
          end
        end
        ST_SCAN: begin
          // leave when the next id is not yet done
          if (!stat_i.mark0) begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/ioc_dp.sv
// Datapath: head id, completion marks, active count and result registers.
module ioc_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic        [ioc_pkg::ID_W-1:0]      cfg_wdata_i,
  input  logic        [ioc_pkg::ACT_W-1:0]     action_i,
  input  logic        [ioc_pkg::ID_W-1:0]      item_id_i,
  input  logic signed [ioc_pkg::SEED_W-1:0]    seed_i,
  input  logic                                 gen_done_i,
  input  logic                                 halt_i,
  input  ioc_pkg::ioc_cmd_t                    cmd_i,
  output ioc_pkg::ioc_stat_t                   stat_o,
  output logic        [ioc_pkg::COUNT_W-1:0]   start_count_o,
  output logic                                 progress_valid_o,
  output logic signed [ioc_pkg::SEED_W-1:0]    progress_seed_o,
  output logic                                 finished_o,
  output logic        [ioc_pkg::ID_W-1:0]      head_now_o,
  output logic                                 out_of_window_o
);

  logic [ioc_pkg::ID_W-1:0]   head_q, head_d;
  logic [ioc_pkg::WINDOW-1:0] marks_q, marks_d;
  logic [ioc_pkg::CNT_W-1:0]  active_q, active_d;
  logic                       all_done_q, all_done_d;

  logic [ioc_pkg::RUN_W-1:0]  run_q, run_d;
  logic                       pvalid_q, pvalid_d;
  logic signed [ioc_pkg::SEED_W-1:0] pseed_q, pseed_d;
  logic                       fin_q, fin_d;
  logic                       oow_q, oow_d;

  logic [ioc_pkg::CNT_W-1:0]  count_dn;
  logic                       all_done_new;
  logic [ioc_pkg::ID_W-1:0]   offset;
  logic                       in_window;
  logic                       win_open;

  // Offset of the item from the head, modulo 2^64
  assign offset       = item_id_i - head_q;
  assign in_window    = offset < ioc_pkg::ID_W'(ioc_pkg::WINDOW);
  assign count_dn     = (active_q != '0) ? active_q - 1'b1 : active_q;
  assign all_done_new = all_done_q | gen_done_i;
  assign win_open     = !all_done_new && !halt_i;

  always_comb begin
    stat_o            = '0;
    stat_o.retire_hit = (action_i == ioc_pkg::ACT_DONE) && win_open && (offset == '0);
    stat_o.mark0      = marks_q[0];
  end

  // Next state of the window and the result word
  always_comb begin
    head_d     = head_q;
    marks_d    = marks_q;
    active_d   = active_q;
    all_done_d = all_done_q;
    run_d      = run_q;
    pvalid_d   = pvalid_q;
    pseed_d    = pseed_q;
    fin_d      = fin_q;
    oow_d      = oow_q;

    if (cmd_i.accept) begin
      run_d    = '0;
      pvalid_d = 1'b0;
      pseed_d  = '0;
      fin_d    = 1'b0;
      oow_d    = 1'b0;
      case (action_i)
        ioc_pkg::ACT_DONE: begin
          active_d   = count_dn;
          all_done_d = all_done_new;
          fin_d      = (count_dn == '0);
          if (win_open) begin
            if (offset == '0) begin
              // head retires; slide by one and scan for more
              marks_d  = marks_q >> 1;
              head_d   = head_q + 1'b1;
              run_d    = ioc_pkg::RUN_W'(1);
              pvalid_d = 1'b1;
              pseed_d  = seed_i;
            end else if (in_window) begin
              marks_d[offset[ioc_pkg::IDX_W-1:0]] = 1'b1;
            end else begin
              oow_d = 1'b1;
            end
          end
        end
        ioc_pkg::ACT_CANCEL: begin
          active_d = count_dn;
          fin_d    = (count_dn == '0);
        end
        ioc_pkg::ACT_START: begin
          if (active_q != ioc_pkg::CNT_MAX) begin
            active_d = active_q + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end else if (cmd_i.step) begin
      // next id was already done: retire it too
      marks_d = marks_q >> 1;
      head_d  = head_q + 1'b1;
      run_d   = run_q + 1'b1;
    end

    // register write reloads the window
    if (cfg_we_i) begin
      head_d     = cfg_wdata_i;
      marks_d    = '0;
      all_done_d = 1'b0;
    end
  end

  // Window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      marks_q    <= '0;
      active_q   <= '0;
      all_done_q <= 1'b0;
    end else begin
      head_q     <= head_d;
      marks_q    <= marks_d;
      active_q   <= active_d;
      all_done_q <= all_done_d;
    end
  end

  // Result word registers
  always_ff @(posedge clk_i) begin
    run_q    <= run_d;
    pvalid_q <= pvalid_d;
    pseed_q  <= pseed_d;
    fin_q    <= fin_d;
    oow_q    <= oow_d;
  end

  assign start_count_o    = (int'(run_q) > ioc_pkg::START_MAX) ?
                            ioc_pkg::COUNT_W'(ioc_pkg::START_MAX) :
                            ioc_pkg::COUNT_W'(run_q);
  assign progress_valid_o = pvalid_q;
  assign progress_seed_o  = pseed_q;
  assign finished_o       = fin_q;
  assign head_now_o       = head_q;
  assign out_of_window_o  = oow_q;

endmodule

### rtl/in_order_completion_window_core.sv
// Top level of the in-order completion window: controller plus datapath.
//
// Usage: a word (action, item id, seed, gen_done, halt) is taken at a clock
// edge with start high and busy low. Every word yields one result word, shown
// for exactly one cycle with done_o high; the receiver cannot hold it off.
// Start, cancel, out-of-window and non-head completions, and completions
// taken while halted or all done: result in the cycle after the accept, busy
// stays low, a new word may follow every cycle. Other head completions: the
// controller retires one id per cycle while the next id is marked done; busy
// stays high while it scans the k contiguous done ids after the head (at most
// WINDOW-1), and the result is strobed at the edge where busy falls.
// The start_id register is written through cfg_we_i/cfg_wdata_i; the user
// must write it only while idle, as the block does not enforce this. A write
// reloads the head id and clears the marks and the all-done flag.
// Reset clears the head id, marks, active count and all-done flag; no result
// is strobed until a word is accepted.
module in_order_completion_window_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic        [ioc_pkg::ID_W-1:0]      cfg_wdata_i,
  input  logic                                 start,
  output logic                                 busy,
  input  logic        [ioc_pkg::ACT_W-1:0]     action_i,
  input  logic        [ioc_pkg::ID_W-1:0]      item_id_i,
  input  logic signed [ioc_pkg::SEED_W-1:0]    seed_i,
  input  logic                                 gen_done_i,
  input  logic                                 halt_i,
  output logic                                 done_o,
  output logic        [ioc_pkg::COUNT_W-1:0]   start_count_o,
  output logic                                 progress_valid_o,
  output logic signed [ioc_pkg::SEED_W-1:0]    progress_seed_o,
  output logic                                 finished_o,
  output logic        [ioc_pkg::ID_W-1:0]      head_now_o,
  output logic                                 out_of_window_o
);

  ioc_pkg::ioc_cmd_t  cmd;
  ioc_pkg::ioc_stat_t stat;

  ioc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  ioc_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .action_i         (action_i),
    .item_id_i        (item_id_i),
    .seed_i           (seed_i),
    .gen_done_i       (gen_done_i),
    .halt_i           (halt_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .start_count_o    (start_count_o),
    .progress_valid_o (progress_valid_o),
    .progress_seed_o  (progress_seed_o),
    .finished_o       (finished_o),
    .head_now_o       (head_now_o),
    .out_of_window_o  (out_of_window_o)
  );

endmodule

### rtl/ioc_checker.sv
// Port-level checks for the in-order completion window, bound to the top level.
module ioc_port_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start,
  input logic                               busy,
  input logic                               done_o,
  input logic [ioc_pkg::COUNT_W-1:0]        start_count_o,
  input logic                               progress_valid_o,
  input logic                               out_of_window_o
);

  // A result word never shows while a scan is running
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobed while busy");

  // A scan only starts from an accepted word
  a_busy_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start");

  // The end of a scan is followed by its result in the same cycle
  a_scan_ends_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("scan ended without a result");

  // New starts are requested exactly when the head retired
  a_count_with_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (progress_valid_o == (start_count_o != '0)))
    else $error("start count and progress disagree");

  // A retire and an out-of-window flag never come together
  a_retire_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && progress_valid_o) |-> !out_of_window_o)
    else $error("retire flagged out of window");

endmodule

bind in_order_completion_window_core ioc_port_checker u_ioc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .done_o           (done_o),
  .start_count_o    (start_count_o),
  .progress_valid_o (progress_valid_o),
  .out_of_window_o  (out_of_window_o)
);
